// File: hw/rtl/fssm_pkg.sv
// ----------------------------------------------------------------------------
// fssm_pkg
// Types, register indexes and helpers shared by the substring search block.
// ----------------------------------------------------------------------------
package fssm_pkg;

    // Fixed widths of the configuration port and the result fields.
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 64;
    localparam int LEN_W        = 5;
    localparam int NEEDLE_BYTES = 16;
    localparam int END_OFF_W    = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LENGTH = 2'd2;

    // Needle bytes, byte zero in the low bits.
    typedef logic [NEEDLE_BYTES-1:0][7:0] t_needle;

    // One result item as it leaves the match tracker.
    typedef struct packed {
        logic                 match_found;
        logic [END_OFF_W-1:0] end_offset;
        logic                 not_found;
    } t_result;

    // Needle byte j; bytes past the configured sixteen read as zero.
    function automatic logic [7:0] needle_byte(t_needle n, logic [LEN_W-1:0] j);
        logic [7:0] b;
        b = 8'd0;
        if (j < LEN_W'(NEEDLE_BYTES)) begin
            b = n[j[3:0]];
        end
        return b;
    endfunction

endpackage

// File: hw/rtl/fssm_if.sv
// ----------------------------------------------------------------------------
// fssm_if
// Valid/ready channels of the substring search block: haystack bytes,
// results and configuration writes.
// ----------------------------------------------------------------------------
interface fssm_hay_if;
    logic       valid;
    logic       ready;
    logic [7:0] hay_byte;
    logic       buffer_start;
    logic       buffer_end;

    modport source (output valid, output hay_byte, output buffer_start,
                    output buffer_end, input ready);
    modport sink   (input valid, input hay_byte, input buffer_start,
                    input buffer_end, output ready);
endinterface

interface fssm_res_if;
    logic                              valid;
    logic                              ready;
    logic                              match_found;
    logic [fssm_pkg::END_OFF_W-1:0]    end_offset;
    logic                              not_found;

    modport source (output valid, output match_found, output end_offset,
                    output not_found, input ready);
    modport sink   (input valid, input match_found, input end_offset,
                    input not_found, output ready);
endinterface

interface fssm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [fssm_pkg::CFG_IDX_W-1:0]    index;
    logic [fssm_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/first_substring_match_stream_core.sv
// ----------------------------------------------------------------------------
// first_substring_match_stream_core
// Streaming first-occurrence search of a configured needle in byte buffers.
// ----------------------------------------------------------------------------
// Usage: haystack bytes arrive on i_hay, one byte per transfer, with
// buffer_start and buffer_end marking the edges of each buffer. Every byte
// transfer yields exactly one result transfer on o_res, through the result
// register: match_found with end_offset on the byte that completes the
// first match of the buffer, not_found on the last byte of a buffer without
// a match, all zero otherwise. An empty needle matches on the first byte with
// end offset zero.
// Throughput is one byte per clock while the receiver takes each result. The
// window is a row of MAX_NEEDLE cells that shift at each transfer and compare
// in parallel; the result register holds the result of each byte.
// The needle is loaded through i_cfg (low bytes, high bytes, length), which
// is always ready and is meant to be written while no byte is in flight.
// After reset the needle is empty and the next byte opens a new buffer.
// When the receiver stalls, the held result keeps i_hay not ready until it
// has been taken; no byte is lost or dropped.
// ----------------------------------------------------------------------------
module first_substring_match_stream_core #(
    parameter int MAX_NEEDLE  = 16,
    parameter int OFFSET_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fssm_cfg_if.sink    i_cfg,
    fssm_hay_if.sink    i_hay,
    fssm_res_if.source  o_res
);
    import fssm_pkg::*;

    localparam int LEN_CMP_W = 8;

    // Configuration registers.
    logic [CFG_DATA_W-1:0] r_needle_low;
    logic [CFG_DATA_W-1:0] r_needle_high;
    logic [LEN_W-1:0]      r_needle_length;
    t_needle               w_needle;
    logic [LEN_W-1:0]      w_eff_len;

    // Window chain.
    logic [MAX_NEEDLE-1:0]     w_ok;
    logic [MAX_NEEDLE:0][7:0]  w_chain;
    logic                      w_window_eq;

    // Control and output register.
    logic                   w_take;
    logic                   w_cfg_write;
    t_result                w_result;
    logic [OFFSET_BITS-1:0] w_seen;
    logic                   r_out_valid, n_out_valid;
    t_result                r_out;

    // ------------------------------------------------------------------------
    // Configuration: a write completes on every cycle the source offers one.
    // Indexes outside the register list are simply ignored.
    // ------------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;
    assign w_cfg_write = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle_low    <= '0;
            r_needle_high   <= '0;
            r_needle_length <= '0;
        end else if (w_cfg_write) begin
            unique case (i_cfg.index)
                CFG_NEEDLE_LOW:    r_needle_low    <= i_cfg.data;
                CFG_NEEDLE_HIGH:   r_needle_high   <= i_cfg.data;
                CFG_NEEDLE_LENGTH: r_needle_length <= i_cfg.data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_needle = t_needle'({r_needle_high, r_needle_low});

    // A length beyond the window depth is treated as the full window.
    assign w_eff_len = (LEN_CMP_W'(r_needle_length) > LEN_CMP_W'(MAX_NEEDLE))
                       ? LEN_W'(MAX_NEEDLE) : r_needle_length;

    // ------------------------------------------------------------------------
    // Byte window: the new byte enters cell zero and each cell hands its
    // byte to the next at every input transfer. Each cell compares the byte
    // entering it, so the window is checked including the current byte.
    // ------------------------------------------------------------------------
    assign w_chain[0] = i_hay.hay_byte;

    for (genvar k = 0; k < MAX_NEEDLE; k++) begin : g_cell
        fssm_cell #(
            .K (k)
        ) u_cell (
            .i_clk     (i_clk),
            .i_shift   (w_take),
            .i_byte    (w_chain[k]),
            .i_needle  (w_needle),
            .i_eff_len (w_eff_len),
            .o_byte    (w_chain[k+1]),
            .o_ok      (w_ok[k])
        );
    end

    assign w_window_eq = &w_ok;

    // ------------------------------------------------------------------------
    // Handshake: a byte is taken whenever the output register is empty or is
    // being emptied in the same cycle, so a stalled result only blocks input
    // while it is actually held.
    // ------------------------------------------------------------------------
    assign i_hay.ready = !r_out_valid || o_res.ready;
    assign w_take      = i_hay.valid && i_hay.ready;

    fssm_tracker #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_start     (i_hay.buffer_start),
        .i_end       (i_hay.buffer_end),
        .i_window_eq (w_window_eq),
        .i_eff_len   (w_eff_len),
        .o_result    (w_result),
        .o_seen      (w_seen)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_take) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= w_result;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.match_found = r_out.match_found;
    assign o_res.end_offset  = r_out.end_offset;
    assign o_res.not_found   = r_out.not_found;

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    // A buffer cannot both report its first match and end without one.
    a_found_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !(o_res.match_found && o_res.not_found))
        else $error("match_found and not_found raised together");

    // The offset is only carried alongside a match.
    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.match_found) |-> (o_res.end_offset == '0))
        else $error("end_offset non-zero without a match");

    // The last byte of a buffer leaves the byte count cleared.
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_hay.buffer_end) |=> (w_seen == '0))
        else $error("byte count not cleared after buffer end");

    // A held result that is not taken blocks the next byte.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |-> !w_take)
        else $error("byte taken while result register is stalled");

endmodule

// File: hw/rtl/fssm_cell.sv
// ----------------------------------------------------------------------------
// fssm_cell
// One window cell: holds one haystack byte, passes it on at each transfer and
// checks the byte entering it against its needle byte.
// ----------------------------------------------------------------------------
module fssm_cell #(
    parameter int K = 0
) (
    input  logic                        i_clk,
    input  logic                        i_shift,
    input  logic [7:0]                  i_byte,
    input  fssm_pkg::t_needle           i_needle,
    input  logic [fssm_pkg::LEN_W-1:0]  i_eff_len,
    output logic [7:0]                  o_byte,
    output logic                        o_ok
);
    import fssm_pkg::*;

    localparam int POS_W = 7;

    logic [7:0]       r_byte;
    logic [POS_W-1:0] w_len_ext;
    logic [POS_W-1:0] w_pos;
    logic             w_active;
    logic [7:0]       w_expect;

    // Cell K sees the byte K transfers old; it must equal needle byte len-1-K.
    assign w_len_ext = POS_W'(i_eff_len);
    assign w_active  = w_len_ext > POS_W'(K);
    assign w_pos     = w_len_ext - POS_W'(1) - POS_W'(K);
    assign w_expect  = needle_byte(i_needle, w_pos[LEN_W-1:0]);
    assign o_ok      = !w_active || (i_byte == w_expect);

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

// File: hw/rtl/fssm_tracker.sv
// ----------------------------------------------------------------------------
// fssm_tracker
// Per-buffer bookkeeping: byte count, first-match flag and the result fields.
// ----------------------------------------------------------------------------
module fssm_tracker #(
    parameter int OFFSET_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_take,
    input  logic                        i_start,
    input  logic                        i_end,
    input  logic                        i_window_eq,
    input  logic [fssm_pkg::LEN_W-1:0]  i_eff_len,
    output fssm_pkg::t_result           o_result,
    output logic [OFFSET_BITS-1:0]      o_seen
);
    import fssm_pkg::*;

    localparam int CLAMP_W = (OFFSET_BITS > END_OFF_W) ? OFFSET_BITS : END_OFF_W;
    localparam logic [OFFSET_BITS-1:0] SEEN_MAX = {OFFSET_BITS{1'b1}};

    logic [OFFSET_BITS-1:0] r_seen, n_seen;
    logic                   r_matched, n_matched;
    logic [OFFSET_BITS-1:0] w_seen_cur;
    logic                   w_matched_cur;
    logic [OFFSET_BITS:0]   w_seen_inc;
    logic [OFFSET_BITS-1:0] w_off_sat;
    logic [CLAMP_W-1:0]     w_off_ext;
    logic                   w_empty;
    logic                   w_hit;

    // A start mark abandons whatever the current buffer had gathered.
    assign w_seen_cur    = i_start ? '0 : r_seen;
    assign w_matched_cur = i_start ? 1'b0 : r_matched;
    assign w_seen_inc    = {1'b0, w_seen_cur} + (OFFSET_BITS+1)'(1);
    assign w_empty       = (i_eff_len == '0);

    assign w_hit = !w_matched_cur &&
                   (w_empty ||
                    ((w_seen_inc >= (OFFSET_BITS+1)'(i_eff_len)) && i_window_eq));

    assign w_off_sat = (w_seen_cur == SEEN_MAX) ? w_seen_cur
                                                : w_seen_inc[OFFSET_BITS-1:0];
    assign w_off_ext = CLAMP_W'(w_off_sat);

    always_comb begin
        o_result.match_found = w_hit;
        o_result.end_offset  = '0;
        if (w_hit && !w_empty) begin
            o_result.end_offset = (w_off_ext > CLAMP_W'({END_OFF_W{1'b1}}))
                                  ? {END_OFF_W{1'b1}} : w_off_ext[END_OFF_W-1:0];
        end
        o_result.not_found = i_end && !(w_matched_cur || w_hit);
    end

    always_comb begin
        n_seen    = r_seen;
        n_matched = r_matched;
        if (i_take) begin
            if (i_end) begin
                n_seen    = '0;
                n_matched = 1'b0;
            end else begin
                n_seen    = (w_seen_cur == SEEN_MAX) ? w_seen_cur
                                                     : w_seen_inc[OFFSET_BITS-1:0];
                n_matched = w_matched_cur || w_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= '0;
            r_matched <= 1'b0;
        end else begin
            r_seen    <= n_seen;
            r_matched <= n_matched;
        end
    end

    assign o_seen = r_seen;

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming first-match substring search. Bytes
// are sent as directed cases, then as random buffers that often hold the
// needle. Random idle cycles are drawn on both handshakes. A scoreboard
// predicts one result per accepted byte and compares it field by field with
// each result transfer.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fssm_pkg::*;

    // The offset counter saturates at this value (OFFSET_BITS of sixteen).
    localparam int SEEN_MAX     = 65535;
    // Rough number of random haystack bytes after the directed cases.
    localparam int RANDOM_BYTES = 500;
    localparam int CYCLE_LIMIT  = 100000;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the search state and the needle, works
    // out the result of every accepted byte and queues it until the matching
    // result transfer turns up.
    // ------------------------------------------------------------------------
    class match_scoreboard;
        logic [127:0]   needle_bits;
        logic [LEN_W-1:0] needle_size;
        logic [7:0]     window [NEEDLE_BYTES];
        logic [15:0]    seen;
        bit             matched;
        t_result        pending_results [$];
        int             errors;

        function new();
            needle_bits = '0;
            needle_size = '0;
            foreach (window[k]) window[k] = 8'd0;
            seen        = '0;
            matched     = 1'b0;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_NEEDLE_LOW:    needle_bits[63:0]   = data;
                CFG_NEEDLE_HIGH:   needle_bits[127:64] = data;
                CFG_NEEDLE_LENGTH: needle_size         = data[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_byte(logic [7:0] b, logic first, logic last);
            int      len;
            int      off;
            bit      hit;
            bit      same;
            t_result want;
            len = (int'(needle_size) > NEEDLE_BYTES) ? NEEDLE_BYTES : int'(needle_size);
            if (first) begin
                seen    = '0;
                matched = 1'b0;
            end
            for (int k = NEEDLE_BYTES - 1; k > 0; k--) window[k] = window[k-1];
            window[0] = b;
            hit = 1'b0;
            off = 0;
            if (!matched) begin
                if (len == 0) begin
                    hit = 1'b1;
                end else if (int'(seen) + 1 >= len) begin
                    same = 1'b1;
                    for (int j = 0; j < len; j++) begin
                        if (window[len-1-j] != needle_bits[8*j +: 8]) same = 1'b0;
                    end
                    if (same) begin
                        hit = 1'b1;
                        off = int'(seen) + 1;
                        if (off > SEEN_MAX) off = SEEN_MAX;
                    end
                end
            end
            if (seen != 16'hFFFF) seen = seen + 16'd1;
            if (hit) matched = 1'b1;
            want.match_found = hit;
            want.end_offset  = END_OFF_W'(off);
            want.not_found   = last && !matched;
            if (last) begin
                seen    = '0;
                matched = 1'b0;
            end
            pending_results.push_back(want);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected: %s %0d %0d %0d",
                         $time, "match_found end_offset not_found",
                         got.match_found, got.end_offset, got.not_found);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.match_found !== want.match_found) begin
                $display("%0t: match_found expected %0d actual %0d",
                         $time, want.match_found, got.match_found);
                errors++;
            end
            if (got.end_offset !== want.end_offset) begin
                $display("%0t: end_offset expected %0d actual %0d",
                         $time, want.end_offset, got.end_offset);
                errors++;
            end
            if (got.not_found !== want.not_found) begin
                $display("%0t: not_found expected %0d actual %0d",
                         $time, want.not_found, got.not_found);
                errors++;
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    fssm_cfg_if cfg ();
    fssm_hay_if hay ();
    fssm_res_if res ();

    first_substring_match_stream_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_hay   (hay),
        .o_res   (res)
    );

    match_scoreboard board = new();

    // When calm is set, neither side inserts idle cycles, so stretches of
    // back-to-back transfers are exercised as well.
    bit         calm;
    bit         wide;
    logic [7:0] alpha [4];
    int         bytes_sent;
    int         cycle_count;

    always #2 i_clk = ~i_clk;

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Haystack bytes come either from a small alphabet, so that matches are
    // frequent, or from the full byte range as noise.
    function automatic logic [7:0] pick_byte();
        if (wide) begin
            return 8'($urandom_range(0, 255));
        end
        return alpha[$urandom_range(0, 3)];
    endfunction

    // Writes all three needle registers in back-to-back transfers. The valid
    // stays high across them and drops only after the last one.
    task automatic load_needle(input logic [63:0] low, input logic [63:0] high,
                               input logic [63:0] len_word);
        logic [CFG_IDX_W-1:0]  idx [3];
        logic [CFG_DATA_W-1:0] val [3];
        idx[0] = CFG_NEEDLE_LOW;    val[0] = low;
        idx[1] = CFG_NEEDLE_HIGH;   val[1] = high;
        idx[2] = CFG_NEEDLE_LENGTH; val[2] = len_word;
        for (int r = 0; r < 3; r++) begin
            cfg.valid <= 1'b1;
            cfg.index <= idx[r];
            cfg.data  <= val[r];
            do @(posedge i_clk); while (!cfg.ready);
            board.write_reg(idx[r], val[r]);
        end
        cfg.valid <= 1'b0;
    endtask

    // One haystack transfer. The idle gap is drawn first; the valid is only
    // lowered when a gap is actually wanted, so consecutive bytes with no gap
    // keep it high without a second assignment in the same time step.
    task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            hay.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        hay.valid        <= 1'b1;
        hay.hay_byte     <= b;
        hay.buffer_start <= first;
        hay.buffer_end   <= last;
        do @(posedge i_clk); while (!hay.ready);
        board.note_byte(b, first, last);
        bytes_sent++;
    endtask

    // Sends a whole buffer. Without the noisy flag, the start mark goes on
    // the first byte and the end mark on the last, each only when asked for;
    // with it, both marks are drawn at random on every byte.
    task automatic send_buffer(input logic [7:0] bytes_q [$], input bit mark_start,
                               input bit mark_end, input bit noisy);
        logic first;
        logic last;
        for (int n = 0; n < bytes_q.size(); n++) begin
            if (noisy) begin
                first = 1'($urandom_range(0, 1));
                last  = 1'($urandom_range(0, 1));
            end else begin
                first = mark_start && (n == 0);
                last  = mark_end && (n == bytes_q.size() - 1);
            end
            send_byte(bytes_q[n], first, last);
        end
    endtask

    // Holds the sender off until every expected result has been taken, then
    // lets the result register settle.
    task automatic drain_results();
        hay.valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Result side: draws a stall per result, then keeps ready high until a
    // transfer happens and hands the result to the scoreboard.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int      stall;
        t_result got;
        res.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                res.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res.ready <= 1'b1;
            do @(posedge i_clk); while (!res.valid);
            got.match_found = res.match_found;
            got.end_offset  = res.end_offset;
            got.not_found   = res.not_found;
            board.check_result(got);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [7:0]   hay_q [$];
        logic [127:0] pat;
        logic [63:0]  upper;
        int           phase;
        int           code;
        int           len;
        int           eff;
        int           nbuf;
        int           blen;
        int           pos;
        int           kind;

        i_rst_n          <= 1'b0;
        cfg.valid        <= 1'b0;
        cfg.index        <= CFG_NEEDLE_LOW;
        cfg.data         <= '0;
        hay.valid        <= 1'b0;
        hay.hay_byte     <= 8'd0;
        hay.buffer_start <= 1'b0;
        hay.buffer_end   <= 1'b0;
        calm             = 1'b0;
        wide             = 1'b0;
        bytes_sent       = 0;
        cycle_count      = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. The needle is empty after reset, so the very first
        // byte, which carries no start mark, must match at offset zero; the
        // closing byte then reports nothing because the match came earlier.
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
        drain_results();

        // A full sixteen-byte needle using both registers and the byte
        // extremes, found in a buffer of exactly its own length.
        pat = 128'h0F1E2D3C4B5A6978_877F0110FE80FF00;
        load_needle(pat[63:0], pat[127:64], 64'd16);
        hay_q = {};
        for (int j = 0; j < 16; j++) hay_q.push_back(pat[8*j +: 8]);
        send_buffer(hay_q, 1'b1, 1'b1, 1'b0);
        drain_results();

        // Three-byte needle: a buffer shorter than the needle, a one-byte
        // buffer, and a start mark that abandons a buffer before it ends.
        load_needle(64'h434241, 64'h0, 64'd3);
        send_buffer('{8'h41, 8'h42}, 1'b1, 1'b1, 1'b0);
        send_buffer('{8'h41}, 1'b1, 1'b1, 1'b0);
        send_buffer('{8'h41, 8'h42}, 1'b1, 1'b0, 1'b0);
        send_buffer('{8'h41, 8'h42, 8'h43}, 1'b1, 1'b1, 1'b0);

        // Random part: each phase loads a new needle while idle and then sends
        // a handful of buffers. The first phases walk through the empty, full,
        // overlong and short needle settings before the choice becomes random.
        phase = 0;
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            drain_results();
            calm = ($urandom_range(0, 3) == 0);
            wide = ($urandom_range(0, 4) == 0);
            foreach (alpha[a]) alpha[a] = 8'($urandom_range(0, 255));
            if (phase == 1) begin
                alpha[0] = 8'h00;
                alpha[1] = 8'hFF;
            end
            code = (phase < 4) ? phase : $urandom_range(0, 9);
            case (code)
                0:       len = 0;
                1:       len = 16;
                2:       len = $urandom_range(17, 31);
                default: len = $urandom_range(1, 6);
            endcase
            for (int j = 0; j < 16; j++) pat[8*j +: 8] = pick_byte();
            upper = {$urandom, $urandom};
            load_needle(pat[63:0], pat[127:64], (upper & ~64'h1F) | 64'(len));
            eff  = (len > 16) ? 16 : len;
            nbuf = $urandom_range(2, 6);
            for (int i = 0; i < nbuf; i++) begin
                blen  = $urandom_range(1, eff + 8);
                hay_q = {};
                for (int n = 0; n < blen; n++) hay_q.push_back(pick_byte());
                // Plant the needle in about half the buffers that can hold it.
                if (eff > 0 && eff <= blen && $urandom_range(0, 1) == 1) begin
                    pos = $urandom_range(0, blen - eff);
                    for (int j = 0; j < eff; j++) hay_q[pos+j] = pat[8*j +: 8];
                end
                // Mostly well-formed buffers; some lack the start mark, some
                // lack the end mark, and some carry marks at random.
                kind = $urandom_range(0, 9);
                if ($urandom_range(0, 7) == 0) drain_results();
                send_buffer(hay_q, kind != 0, kind != 1, kind == 2);
            end
            phase++;
        end

        // Wait for the last results, then for any stray transfer.
        drain_results();
        repeat (8) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
